@@ rtl/bccfr_pkg.sv @@
// Package for the XOR-checked frame receiver: frame geometry, header bytes
// and the result word type. No dependencies.
`timescale 1ns / 1ps

package bccfr_pkg;

  // Frame geometry
  localparam int FRAME_LEN = 11;
  localparam int BYTE_W    = 8;
  localparam int FILL_W    = $clog2(FRAME_LEN + 1);
  localparam int COUNT_W   = 16;

  // Header bytes expected at the start of a frame
  localparam logic [BYTE_W-1:0] HDR0 = 8'h10;
  localparam logic [BYTE_W-1:0] HDR1 = 8'h82;

  // Byte positions inside the window
  localparam int LEFT_HI_POS  = 2;
  localparam int LEFT_LO_POS  = 3;
  localparam int RIGHT_HI_POS = 4;
  localparam int RIGHT_LO_POS = 5;
  localparam int BCC_POS      = FRAME_LEN - 2;

  typedef logic [BYTE_W-1:0] byte_t;

  // Result word, left count in the low bits
  typedef struct packed {
    logic [COUNT_W-1:0] right_count;
    logic [COUNT_W-1:0] left_count;
  } frame_result_t;

  // Handoff from the frame checker to the output register
  typedef struct packed {
    logic          hit;
    frame_result_t result;
  } check_out_t;

endpackage

@@ rtl/bccfr_in_stage.sv @@
// Input register stage of the frame receiver: holds one received word.
// Depends on bccfr_pkg.
`timescale 1ns / 1ps

module bccfr_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  bccfr_pkg::byte_t in_byte,
  input  logic            take,       // downstream consumes the held word
  output logic            hold_vld,
  output bccfr_pkg::byte_t hold_byte
);

  logic             vld_r, vld_nxt;
  bccfr_pkg::byte_t byte_r;

  // Accept when empty or when the held word leaves this cycle.
  assign in_tready = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (in_tready) begin
      vld_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_byte;
    end
  end

  assign hold_vld  = vld_r;
  assign hold_byte = byte_r;

endmodule

@@ rtl/bccfr_frame_check.sv @@
// Sliding byte window with fill count, header compare and XOR check.
// Depends on bccfr_pkg.
`timescale 1ns / 1ps

module bccfr_frame_check (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,      // shift the new byte in this cycle
  input  bccfr_pkg::byte_t      new_byte,
  output bccfr_pkg::check_out_t chk
);

  bccfr_pkg::byte_t window_r [bccfr_pkg::FRAME_LEN];
  bccfr_pkg::byte_t win_nxt  [bccfr_pkg::FRAME_LEN];
  logic [bccfr_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic             full_nxt;
  logic             hdr_ok;
  logic             bcc_ok;
  bccfr_pkg::byte_t bcc_acc;

  // Window as it stands after the new byte: oldest byte at index 0.
  always_comb begin
    for (int i = 0; i < bccfr_pkg::FRAME_LEN - 1; i++) begin
      win_nxt[i] = window_r[i+1];
    end
    win_nxt[bccfr_pkg::FRAME_LEN-1] = new_byte;
  end

  // The window is full once the last free slot is being written.
  assign full_nxt = (fill_r >= bccfr_pkg::FILL_W'(bccfr_pkg::FRAME_LEN - 1));

  // Header compare and block check over the leading bytes.
  always_comb begin
    bcc_acc = '0;
    for (int k = 0; k < bccfr_pkg::BCC_POS; k++) begin
      bcc_acc = bcc_acc ^ win_nxt[k];
    end
  end

  assign hdr_ok = (win_nxt[0] == bccfr_pkg::HDR0) && (win_nxt[1] == bccfr_pkg::HDR1);
  assign bcc_ok = (bcc_acc == win_nxt[bccfr_pkg::BCC_POS]);

  assign chk.hit = full_nxt && hdr_ok && bcc_ok;
  assign chk.result.left_count  = {win_nxt[bccfr_pkg::LEFT_HI_POS],
                                   win_nxt[bccfr_pkg::LEFT_LO_POS]};
  assign chk.result.right_count = {win_nxt[bccfr_pkg::RIGHT_HI_POS],
                                   win_nxt[bccfr_pkg::RIGHT_LO_POS]};

  // Fill count: empties on an accepted frame, saturates when full.
  always_comb begin
    fill_nxt = fill_r;
    if (step) begin
      if (chk.hit) begin
        fill_nxt = '0;
      end else if (full_nxt) begin
        fill_nxt = bccfr_pkg::FILL_W'(bccfr_pkg::FRAME_LEN);
      end else begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Window shift line, no reset; stale bytes are masked by the fill count.
  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < bccfr_pkg::FRAME_LEN; i++) begin
        window_r[i] <= win_nxt[i];
      end
    end
  end

endmodule

@@ rtl/bccfr_out_stage.sv @@
// Output register for decoded encoder counts.
// Depends on bccfr_pkg.
`timescale 1ns / 1ps

module bccfr_out_stage (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  bccfr_pkg::frame_result_t load_data,
  output logic                     free,      // a new result can be loaded
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output bccfr_pkg::frame_result_t out_data
);

  logic                     vld_r, vld_nxt;
  bccfr_pkg::frame_result_t data_r;

  assign free = !vld_r || out_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (free) begin
      vld_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      data_r <= load_data;
    end
  end

  assign out_tvalid = vld_r;
  assign out_data   = data_r;

endmodule

@@ rtl/bcc_frame_receiver_unit.sv @@
// Top level of the XOR-checked frame receiver.
// Depends on bccfr_pkg, bccfr_in_stage, bccfr_frame_check, bccfr_out_stage.
//
//   Channel | Direction | Payload (lowest bits first)
//   in_     | slave     | tdata[7:0] rx_byte
//   out_    | master    | tdata[15:0] left_count, tdata[31:16] right_count
//
// One received word is accepted every cycle unless a held result stalls the
// input; the result for the word that completes a valid frame passes through
// the input register and then the result register around the window check.
// Reset (rst_n low, synchronous) empties the window and both stage registers.
// A held result stalls the input only when the pending word completes
// another frame; other words keep flowing while the result waits.
`timescale 1ns / 1ps

module bcc_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [15:0] left_count, [31:16] right_count
);

  logic                     hold_vld;
  bccfr_pkg::byte_t         hold_byte;
  logic                     take;
  logic                     out_free;
  bccfr_pkg::check_out_t    chk;
  bccfr_pkg::frame_result_t out_data;

  // Input register
  bccfr_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .take      (take),
    .hold_vld  (hold_vld),
    .hold_byte (hold_byte)
  );

  // A held word moves on unless it completes a frame with no room for it.
  assign take = hold_vld && (!chk.hit || out_free);

  // Window and frame check
  bccfr_frame_check u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (take),
    .new_byte (hold_byte),
    .chk      (chk)
  );

  // Result register
  bccfr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (take && chk.hit),
    .load_data  (chk.result),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_data   (out_data)
  );

  assign out_tdata = out_data;

endmodule
